>>> hw/rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf-8 stream decoder
// used by utf8d_front, utf8d_queue, utf8d_back and utf8_stream_decoder_unit
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned ODATA_W = 24;

  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

  // byte classes by upper bound
  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
  localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

  localparam logic [5:0] CONT_MASK  = 6'h3F;
  localparam logic [4:0] LEAD2_MASK = 5'h1F;
  localparam logic [3:0] LEAD3_MASK = 4'h0F;
  localparam logic [2:0] LEAD4_MASK = 3'h07;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_INVALID
  } byte_class_t;

  // one queued job: a main result, optionally preceded by a replacement
  typedef struct packed {
    logic [CP_W-1:0] cp;      // don't care when err is set
    logic            err;     // main result is the replacement code
    logic            pre_rep; // replacement goes out before the main result
    logic            last;    // main result closes the string
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

>>> hw/rtl/utf8d_front.sv
// utf8d_front: accepts bytes, tracks the open sequence and builds result jobs
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [utf8d_pkg::BYTE_W-1:0]    in_byte,
  input  logic                            in_last,
  input  utf8d_pkg::q_status_t            q_stat,
  output logic                            push,
  output utf8d_pkg::job_t                 push_job
);
  import utf8d_pkg::*;

  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic              accept;
  byte_class_t       bclass;
  logic [CP_W-1:0]   acc_shift;
  logic              emit;
  job_t              job;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign acc_shift = {acc_r[CP_W-7:0], in_byte[5:0] & CONT_MASK};

  always_comb begin
    priority if (in_byte <= ASCII_MAX) bclass = BC_ASCII;
    else if (in_byte <= CONT_MAX)      bclass = BC_CONT;
    else if (in_byte <= LEAD2_MAX)     bclass = BC_LEAD2;
    else if (in_byte <= LEAD3_MAX)     bclass = BC_LEAD3;
    else if (in_byte <= LEAD4_MAX)     bclass = BC_LEAD4;
    else                               bclass = BC_INVALID;
  end

  always_comb begin
    pending_nxt = pending_r;
    acc_nxt     = acc_r;
    emit        = 1'b0;
    job.cp      = acc_shift;
    job.err     = 1'b0;
    job.pre_rep = 1'b0;
    job.last    = in_last;
    unique case (bclass)
      BC_ASCII: begin
        emit        = 1'b1;
        job.pre_rep = (pending_r != '0);
        job.cp      = {{(CP_W-BYTE_W){1'b0}}, in_byte};
        pending_nxt = '0;
      end
      BC_CONT: begin
        if (pending_r != '0) begin
          acc_nxt     = acc_shift;
          pending_nxt = pending_r - 1'b1;
          emit        = (pending_r == PEND_W'(1));
        end else begin
          emit    = 1'b1;
          job.err = 1'b1;
        end
      end
      BC_LEAD2: begin
        pending_nxt = PEND_W'(1);
        acc_nxt     = {{(CP_W-5){1'b0}}, in_byte[4:0] & LEAD2_MASK};
      end
      BC_LEAD3: begin
        pending_nxt = PEND_W'(2);
        acc_nxt     = {{(CP_W-4){1'b0}}, in_byte[3:0] & LEAD3_MASK};
      end
      BC_LEAD4: begin
        pending_nxt = PEND_W'(3);
        acc_nxt     = {{(CP_W-3){1'b0}}, in_byte[2:0] & LEAD4_MASK};
      end
      BC_INVALID: begin
        emit        = 1'b1;
        job.err     = 1'b1;
        pending_nxt = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // unfinished sequence at string end; nothing else was emitted in that case
    if (in_last) begin
      if (pending_nxt != '0) begin
        emit    = 1'b1;
        job.err = 1'b1;
      end
      pending_nxt = '0;
      acc_nxt     = '0;
    end
  end

  assign push     = accept && emit;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      acc_r     <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      acc_r     <= acc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> pending_r == '0 && acc_r == '0)
    else $error("state not cleared after last beat");
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |-> push)
    else $error("last beat produced no result");
`endif

endmodule

>>> hw/rtl/utf8d_queue.sv
// utf8d_queue: small job queue between front and back
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf8d_pkg::job_t      push_job,
  input  logic                 pop,
  output utf8d_pkg::job_t      head_job,
  output utf8d_pkg::q_status_t q_stat
);
  import utf8d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t              slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  assign q_stat.full     = (count_r == CNT_W'(DEPTH));
  assign q_stat.nonempty = (count_r != '0);
  assign head_job        = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.nonempty)
    else $error("pop from empty queue");
`endif

endmodule

>>> hw/rtl/utf8d_back.sv
// utf8d_back: expands queued jobs into result beats on an output register
// depends on utf8d_pkg
`timescale 1ns / 1ps

module utf8d_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [utf8d_pkg::CP_W-1:0]    repl_code,
  input  utf8d_pkg::job_t               head_job,
  input  utf8d_pkg::q_status_t          q_stat,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [utf8d_pkg::CP_W-1:0]    out_cp,
  output logic                          out_err,
  output logic                          out_run_last,
  output logic                          out_end
);
  import utf8d_pkg::*;

  logic            valid_r;
  logic            phase_r, phase_nxt;  // set once the leading replacement went out
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic            err_r, err_nxt;
  logic            run_last_r, run_last_nxt;
  logic            end_r, end_nxt;
  logic            load;
  logic            first_half;

  assign load       = q_stat.nonempty && (!valid_r || out_tready);
  assign first_half = head_job.pre_rep && !phase_r;
  assign pop        = load && !first_half;

  always_comb begin
    phase_nxt    = phase_r;
    cp_nxt       = cp_r;
    err_nxt      = err_r;
    run_last_nxt = run_last_r;
    end_nxt      = end_r;
    if (load) begin
      phase_nxt = first_half;
      if (first_half) begin
        cp_nxt       = repl_code;
        err_nxt      = 1'b1;
        run_last_nxt = 1'b0;
        end_nxt      = 1'b0;
      end else begin
        cp_nxt       = head_job.err ? repl_code : head_job.cp;
        err_nxt      = head_job.err;
        run_last_nxt = 1'b1;
        end_nxt      = head_job.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_r       <= cp_nxt;
    err_r      <= err_nxt;
    run_last_r <= run_last_nxt;
    end_r      <= end_nxt;
  end

  assign out_tvalid   = valid_r;
  assign out_cp       = cp_r;
  assign out_err      = err_r;
  assign out_run_last = run_last_r;
  assign out_end      = end_r;

`ifndef NO_ASSERTIONS
  a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> q_stat.nonempty)
    else $error("second half pending with empty queue");
`endif

endmodule

>>> hw/rtl/utf8_stream_decoder_unit.sv
// utf8_stream_decoder_unit: lenient utf-8 byte stream to code point decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
`timescale 1ns / 1ps

// One byte is taken per beat and up to two code points come out for it. The front
// classifies every byte in the cycle it is accepted and can take a byte each clock;
// the back sends one result beat per clock while the receiver is ready, so a byte
// that yields a replacement and an ascii code point takes two result beats. A queue
// of QUEUE_DEPTH jobs sits between them, so input only stalls when that queue fills.
// On an idle block an accepted byte is written into the queue and then loaded into
// the output register as its first result beat. The replacement code register
// resets to U+FFFD and is meant to be written only while no string is in flight.
module utf8_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,   // replacement_code
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,     // [0] is_error, [1] run_last
  output logic        out_tlast      // string_end
);
  import utf8d_pkg::*;

  logic [CP_W-1:0] repl_code_r;
  logic            push, pop;
  job_t            push_job, head_job;
  q_status_t       q_stat;
  logic [CP_W-1:0] res_cp;
  logic            res_err, res_run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_code_r <= REPL_RESET;
    end else if (cfg_wr_en) begin
      repl_code_r <= cfg_wr_data;
    end
  end

  utf8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  utf8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  utf8d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .repl_code    (repl_code_r),
    .head_job     (head_job),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_cp       (res_cp),
    .out_err      (res_err),
    .out_run_last (res_run_last),
    .out_end      (out_tlast)
  );

  assign out_tdata = {{(ODATA_W-CP_W){1'b0}}, res_cp};
  assign out_tuser = {res_run_last, res_err};

endmodule

>>> tb/tb_utf8_stream_decoder_unit.sv
// tb_utf8_stream_decoder_unit: self-checking testbench for the utf-8 stream decoder
// depends on utf8d_pkg and utf8_stream_decoder_unit; predicts every result beat
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit;

  import utf8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            err;
    logic            run_last;
    logic            str_end;
  } cp_beat_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CP_W-1:0]   cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;    // [7:0] data_byte
  logic              in_tlast;    // last_byte
  logic              out_tvalid;
  logic              out_tready;
  logic [ODATA_W-1:0] out_tdata;  // [20:0] code_point, [23:21] zero
  logic [1:0]        out_tuser;   // [0] is_error, [1] run_last
  logic              out_tlast;   // string_end

  // decoder state as the block should hold it
  logic [CP_W-1:0]   repl_code = REPL_RESET;
  logic [PEND_W-1:0] pend_cnt  = '0;
  logic [CP_W-1:0]   cp_acc    = '0;

  cp_beat_t          cp_expect_q[$];
  logic [BYTE_W-1:0] str_buf[$];
  int                err_count   = 0;
  int                sent_count  = 0;
  int                hold_cnt    = 0;
  bit                src_idle_on = 1'b1;
  bit                snk_idle_on = 1'b1;

  utf8_stream_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void expect_add(input cp_beat_t bt);
    cp_expect_q.insert(cp_expect_q.size(), bt);
  endfunction

  function automatic void buf_add(input logic [BYTE_W-1:0] b);
    str_buf.insert(str_buf.size(), b);
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic lst);
    cp_beat_t beats [0:1];
    int       n;
    n = 0;
    if (b <= ASCII_MAX) begin
      if (pend_cnt != 0) begin
        beats[n] = {repl_code, 1'b1, 2'b00};
        n++;
        pend_cnt = '0;
      end
      beats[n] = {CP_W'(b), 1'b0, 2'b00};
      n++;
    end else if (b <= CONT_MAX) begin
      if (pend_cnt != 0) begin
        cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
        pend_cnt = pend_cnt - 1'b1;
        if (pend_cnt == 0) begin
          beats[n] = {cp_acc, 1'b0, 2'b00};
          n++;
        end
      end else begin
        beats[n] = {repl_code, 1'b1, 2'b00};
        n++;
      end
    end else if (b <= LEAD2_MAX) begin
      pend_cnt = 2'd1;
      cp_acc   = CP_W'(b[4:0]);
    end else if (b <= LEAD3_MAX) begin
      pend_cnt = 2'd2;
      cp_acc   = CP_W'(b[3:0]);
    end else if (b <= LEAD4_MAX) begin
      pend_cnt = 2'd3;
      cp_acc   = CP_W'(b[2:0]);
    end else begin
      beats[n] = {repl_code, 1'b1, 2'b00};
      n++;
      pend_cnt = '0;
    end
    if (lst) begin
      // string closed with a sequence still open
      if (pend_cnt != 0) begin
        beats[n] = {repl_code, 1'b1, 2'b00};
        n++;
      end
      pend_cnt = '0;
      cp_acc   = '0;
    end
    if (n > 0) begin
      beats[n-1].run_last = 1'b1;
      beats[n-1].str_end  = lst;
    end
    for (int i = 0; i < n; i++) expect_add(beats[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [CP_W-1:0] got,
                                 input logic [CP_W-1:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_result();
    cp_beat_t want;
    if (cp_expect_q.size() == 0) begin
      report_mismatch("unexpected beat", out_tdata[CP_W-1:0], '0);
      return;
    end
    want = cp_expect_q.pop_front();
    if (out_tdata[CP_W-1:0] !== want.cp)
      report_mismatch("code_point", out_tdata[CP_W-1:0], want.cp);
    if (out_tuser[0] !== want.err)
      report_mismatch("is_error", CP_W'(out_tuser[0]), CP_W'(want.err));
    if (out_tuser[1] !== want.run_last)
      report_mismatch("run_last", CP_W'(out_tuser[1]), CP_W'(want.run_last));
    if (out_tlast !== want.str_end)
      report_mismatch("string_end", CP_W'(out_tlast), CP_W'(want.str_end));
  endtask

  // predict on input beats first, then check output beats, both on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
  end

  // receiver: random stalls, or always ready when idles are off, or a counted hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else if (snk_idle_on) begin
        out_tready <= ($urandom_range(0, 99) >= 20);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    while (src_idle_on && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // sends n bytes, most significant first, last flag as given on the final one
  task automatic send_str(input logic [31:0] bytes, input int n, input logic lst);
    for (int i = n - 1; i >= 0; i--) send_byte(bytes[8*i +: 8], (i == 0) ? lst : 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_repl(input logic [CP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    repl_code = value;
  endtask

  // mostly well-formed characters, some cut short, some noise bytes
  task automatic send_random_string();
    int nchars;
    int r;
    int kind;
    int ncont;
    str_buf.delete();
    nchars = $urandom_range(1, 12);
    repeat (nchars) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        kind = $urandom_range(1, 4);
        if (kind == 1) buf_add(BYTE_W'($urandom_range(0, 127)));
        else if (kind == 2) buf_add(8'hC0 | BYTE_W'($urandom_range(0, 31)));
        else if (kind == 3) buf_add(8'hE0 | BYTE_W'($urandom_range(0, 15)));
        else buf_add(8'hF0 | BYTE_W'($urandom_range(0, 7)));
        ncont = kind - 1;
        if (r >= 75 && ncont > 0) ncont = $urandom_range(0, ncont - 1);
        repeat (ncont) buf_add(8'h80 | BYTE_W'($urandom_range(0, 63)));
      end else if (r < 95) begin
        buf_add(BYTE_W'($urandom_range(0, 255)));
      end else begin
        buf_add(8'h80 | BYTE_W'($urandom_range(0, 63)));
      end
    end
    foreach (str_buf[i]) send_byte(str_buf[i], i == str_buf.size() - 1);
  endtask

  task automatic run_strings(input int n_bytes);
    int start;
    start = sent_count;
    while (sent_count - start < n_bytes) send_random_string();
  endtask

  task automatic test_directed();
    send_str(32'h00, 1, 1'b0);
    send_str(32'h7F, 1, 1'b0);
    send_str(32'hC2A9, 2, 1'b0);
    send_str(32'hE282AC, 3, 1'b0);
    send_str(32'hF7BFBFBF, 4, 1'b0);     // largest 4-byte value
    send_str(32'hEDA080, 3, 1'b0);       // surrogate passes through
    send_str(32'h80, 1, 1'b0);           // stray continuation
    send_str(32'hE241, 2, 1'b0);         // ascii breaks open sequence
    send_str(32'hE2C3A9, 3, 1'b0);       // new lead drops open sequence
    send_str(32'hFF, 1, 1'b0);
    send_str(32'hF09FF8, 3, 1'b0);       // invalid byte inside sequence
    send_str(32'hE282, 2, 1'b1);         // cut short at string end
    wait_drained();
  endtask

  task automatic test_config_values();
    logic [CP_W-1:0] vals [0:2];
    vals[0] = '0;
    vals[1] = '1;
    vals[2] = CP_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      write_repl(vals[i]);
      send_str(32'h41, 1, 1'b1);
      send_str(32'hBF, 1, 1'b0);
      send_str(32'hF041, 2, 1'b0);
      send_str(32'hF8, 1, 1'b1);
      send_str(32'hC3, 1, 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_random_strings();
    for (int ph = 0; ph < 8; ph++) begin
      write_repl((ph == 0) ? REPL_RESET : CP_W'($urandom));
      run_strings(150);
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    run_strings(250);
    wait_drained();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // receiver held off while the sender keeps going, so the queue fills
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    hold_cnt = 300;
    run_strings(120);
    wait_drained();
    src_idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_values();
    test_random_strings();
    test_no_idle();
    test_backpressure();
    wait_drained();
    if (cp_expect_q.size() != 0)
      report_mismatch("results still expected", CP_W'(cp_expect_q.size()), '0);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_front.sv
hw/rtl/utf8d_queue.sv
hw/rtl/utf8d_back.sv
hw/rtl/utf8_stream_decoder_unit.sv
tb/tb_utf8_stream_decoder_unit.sv
